/* rtl/spectral_line_k_linear_resampler_macros.svh */
// assertion macros shared by the resampler modules
`ifndef SPECTRAL_LINE_K_LINEAR_RESAMPLER_MACROS_SVH
`define SPECTRAL_LINE_K_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SLKR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SLKR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/slkr_pkg.sv */
// shared types and constants of the spectral line resampler
`default_nettype none

package slkr_pkg;

   localparam int MAX_LINE_LENGTH_DEF = 2048;
   localparam int FRACTION_BITS_DEF   = 16;

   localparam int ACTION_W   = 2;
   localparam int TADDR_W    = 11;
   localparam int TPOS_W     = 29;
   localparam int SAMPLE_W   = 16;
   localparam int OUT_POS_W  = 11;
   localparam int CSR_W      = 12;
   localparam int FRAC_W     = TPOS_W + 1;
   localparam int PROD_W     = SAMPLE_W + 1 + FRAC_W;

   localparam logic [CSR_W-1:0] LINE_LENGTH_RESET = 12'd1600;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_DRAIN  = 2'd2,
      ACT_NONE   = 2'd3
   } slkr_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_RDB,
      ST_DIFF,
      ST_MUL,
      ST_RND,
      ST_OUT
   } slkr_state_type;

   typedef struct packed {
      logic start;
      logic rd_bank;
      logic last;
   } slkr_cmd_type;

endpackage

`default_nettype wire

/* rtl/spectral_line_k_linear_resampler.sv */
// top level of the spectral line k-linear resampler
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_stall   action, table address, position, sample
//   rsp_     out        rsp_valid / rsp_stall   resampled value, position, last of line
//   csr_     in         csr_valid / csr_ready   line length
//
// a table load, a first-line sample or an ignored word starts no result and leaves the sequencer idle
// a word that gives a result runs in order through table read, two line store reads on the
//   one read port of the line store ram, subtract, multiply, round, saturate
// a finished result waits in the output register; the next word is taken meanwhile,
//   and a second result waits in the last step until rsp_stall drops
// synchronous reset clears counters, bank and line-valid flag; rams are not cleared
`default_nettype none

module spectral_line_k_linear_resampler #(
   parameter int MAX_LINE_LENGTH = slkr_pkg::MAX_LINE_LENGTH_DEF,
   parameter int FRACTION_BITS   = slkr_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [slkr_pkg::ACTION_W-1:0]          req_action,
   input  wire logic [slkr_pkg::TADDR_W-1:0]           req_table_address,
   input  wire logic signed [slkr_pkg::TPOS_W-1:0]     req_resample_position,
   input  wire logic signed [slkr_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [slkr_pkg::SAMPLE_W-1:0]        rsp_resampled_value,
   output logic [slkr_pkg::OUT_POS_W-1:0]              rsp_output_position,
   output logic                                        rsp_last_of_line,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [slkr_pkg::CSR_W-1:0]             csr_line_length
);

   import slkr_pkg::*;

   localparam int PW    = $clog2(MAX_LINE_LENGTH);
   localparam int LW    = $clog2(MAX_LINE_LENGTH + 1);
   localparam int CMP_W = (LW > CSR_W) ? LW : CSR_W;
   localparam int LS_DEPTH = 2 * (1 << PW);

   logic [CSR_W-1:0]  line_length_ff;
   logic [PW-1:0]     counter_ff, counter_in;
   logic              bank_ff, bank_in;
   logic              prev_valid_ff, prev_valid_in;

   logic              busy;
   logic              accept;
   slkr_action_type   act;
   logic [CMP_W-1:0]  len_c;
   logic [LW-1:0]     len_eff;
   logic [LW-1:0]     len_m1;
   logic              last_c;
   logic              do_line;
   logic              tbl_we;
   logic              line_we;
   slkr_cmd_type      cmd;

   logic signed [TPOS_W-1:0]   tbl_rdata;
   logic [PW:0]                line_raddr;
   logic signed [SAMPLE_W-1:0] line_rdata;

   assign req_stall = busy;
   assign csr_ready = !busy;
   assign accept    = req_valid && !req_stall;
   assign act       = slkr_action_type'(req_action);

   // line length in use, clamped to 2..max
   always_comb begin
      len_c = CMP_W'(line_length_ff);
      priority if (len_c < CMP_W'(2)) begin
         len_eff = LW'(2);
      end else if (len_c > CMP_W'(MAX_LINE_LENGTH)) begin
         len_eff = LW'(MAX_LINE_LENGTH);
      end else begin
         len_eff = LW'(len_c);
      end
      len_m1 = len_eff - 1'b1;
   end

   assign last_c  = (LW'(counter_ff) >= len_m1);
   assign do_line = accept && (act == ACT_SAMPLE || (act == ACT_DRAIN && prev_valid_ff));
   assign line_we = accept && (act == ACT_SAMPLE);
   assign tbl_we  = accept && (act == ACT_LOAD)
                    && (32'(req_table_address) < 32'(MAX_LINE_LENGTH));

   assign cmd.start   = do_line && prev_valid_ff;
   assign cmd.rd_bank = !bank_ff;
   assign cmd.last    = last_c;

   always_comb begin
      counter_in    = counter_ff;
      bank_in       = bank_ff;
      prev_valid_in = prev_valid_ff;
      if (do_line) begin
         if (last_c) begin
            counter_in    = '0;
            bank_in       = !bank_ff;
            prev_valid_in = (act == ACT_SAMPLE);
         end else begin
            counter_in = counter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         counter_ff     <= '0;
         bank_ff        <= 1'b0;
         prev_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            line_length_ff <= csr_line_length;
         end
         counter_ff    <= counter_in;
         bank_ff       <= bank_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   // the table is read at the current counter every cycle
   slkr_ram #(
      .WIDTH (TPOS_W),
      .DEPTH (1 << PW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (PW'(req_table_address)),
      .wr_data (req_resample_position),
      .rd_addr (counter_ff),
      .rd_data (tbl_rdata)
   );

   // both line banks in one ram, bank is the top address bit
   slkr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LS_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr ({bank_ff, counter_ff}),
      .wr_data (req_sample),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   slkr_interp #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_interp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .cmd_pos             (counter_ff),
      .cmd_len_m1          (len_m1),
      .busy                (busy),
      .tbl_rdata           (tbl_rdata),
      .line_raddr          (line_raddr),
      .line_rdata          (line_rdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_resampled_value (rsp_resampled_value),
      .rsp_output_position (rsp_output_position),
      .rsp_last_of_line    (rsp_last_of_line)
   );

`include "spectral_line_k_linear_resampler_macros.svh"

   `SLKR_ASSERT_NXT(a_line_end_clears_count, do_line && last_c, counter_ff == '0,
      "counter not cleared at line end")
   `SLKR_ASSERT_NXT(a_line_end_swaps_bank, do_line && last_c, bank_ff != $past(bank_ff),
      "bank not swapped at line end")

endmodule

`default_nettype wire

/* rtl/slkr_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module slkr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/slkr_interp.sv */
// interpolation sequencer: table word to clamped indices, two line reads, subtract, multiply, round, saturate
`default_nettype none

module slkr_interp #(
   parameter int MAX_LINE_LENGTH = slkr_pkg::MAX_LINE_LENGTH_DEF,
   parameter int FRACTION_BITS   = slkr_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire slkr_pkg::slkr_cmd_type                     cmd,
   input  wire logic [$clog2(MAX_LINE_LENGTH)-1:0]         cmd_pos,
   input  wire logic [$clog2(MAX_LINE_LENGTH+1)-1:0]       cmd_len_m1,
   output logic                                            busy,
   input  wire logic signed [slkr_pkg::TPOS_W-1:0]         tbl_rdata,
   output logic [$clog2(MAX_LINE_LENGTH):0]                line_raddr,
   input  wire logic signed [slkr_pkg::SAMPLE_W-1:0]       line_rdata,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic signed [slkr_pkg::SAMPLE_W-1:0]            rsp_resampled_value,
   output logic [slkr_pkg::OUT_POS_W-1:0]                  rsp_output_position,
   output logic                                            rsp_last_of_line
);

   import slkr_pkg::*;

   localparam int PW = $clog2(MAX_LINE_LENGTH);
   localparam int LW = $clog2(MAX_LINE_LENGTH + 1);

   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

   slkr_state_type state_ff, state_in;

   logic                        rd_bank_ff;
   logic                        last_ff;
   logic [PW-1:0]               pos_ff;
   logic [LW-1:0]               len_m1_ff;
   logic [PW-1:0]               left_ff, right_ff;
   logic signed [FRAC_W-1:0]    frac_ff;
   logic signed [SAMPLE_W-1:0]  a_ff;
   logic signed [SAMPLE_W:0]    diff_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    rnd_ff;

   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  value_ff;
   logic [OUT_POS_W-1:0]        opos_ff;
   logic                        olast_ff;

   logic signed [TPOS_W-1:0]    fl;
   logic signed [FRAC_W-1:0]    fl_w;
   logic signed [FRAC_W-1:0]    len_m1_s;
   logic signed [FRAC_W-1:0]    p_w;
   logic [PW-1:0]               len_m1_p;
   logic [PW-1:0]               left_in, right_in;
   logic signed [FRAC_W-1:0]    frac_in;
   logic signed [PROD_W-1:0]    sum_v;
   logic signed [SAMPLE_W-1:0]  value_in;
   logic                        out_free;

   // index clamp from the table word
   always_comb begin
      fl       = tbl_rdata >>> FRACTION_BITS;
      fl_w     = {fl[TPOS_W-1], fl};
      p_w      = {tbl_rdata[TPOS_W-1], tbl_rdata};
      len_m1_s = $signed(FRAC_W'(len_m1_ff));
      len_m1_p = PW'(len_m1_ff);
      priority if (fl_w < 0) begin
         left_in = '0;
      end else if (fl_w > len_m1_s) begin
         left_in = len_m1_p;
      end else begin
         left_in = fl[PW-1:0];
      end
      right_in = (left_in == len_m1_p) ? left_in : left_in + 1'b1;
      // left is at most len_m1 here, so the shifted index stays inside the word
      frac_in  = p_w - $signed(FRAC_W'(left_in) << FRACTION_BITS);
   end

   always_comb begin
      sum_v = {{(PROD_W-SAMPLE_W){a_ff[SAMPLE_W-1]}}, a_ff} + rnd_ff;
      priority if (sum_v > SAT_HI) begin
         value_in = 16'sh7fff;
      end else if (sum_v < SAT_LO) begin
         value_in = -16'sh8000;
      end else begin
         value_in = sum_v[SAMPLE_W-1:0];
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign line_raddr = (state_ff == ST_POS) ? {rd_bank_ff, left_in} : {rd_bank_ff, right_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_POS;
            end
         end
         ST_POS:  state_in = ST_RDB;
         ST_RDB:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_RND;
         ST_RND:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd.start) begin
         rd_bank_ff <= cmd.rd_bank;
         last_ff    <= cmd.last;
         pos_ff     <= cmd_pos;
         len_m1_ff  <= cmd_len_m1;
      end
      if (state_ff == ST_POS) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         frac_ff  <= frac_in;
      end
      if (state_ff == ST_RDB) begin
         a_ff <= line_rdata;
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= {line_rdata[SAMPLE_W-1], line_rdata} - {a_ff[SAMPLE_W-1], a_ff};
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(diff_ff * frac_ff);
      end
      if (state_ff == ST_RND) begin
         // round half up, then floor
         rnd_ff <= (prod_ff + HALF) >>> FRACTION_BITS;
      end
      if (state_ff == ST_OUT && out_free) begin
         value_ff <= value_in;
         opos_ff  <= OUT_POS_W'(pos_ff);
         olast_ff <= last_ff;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resampled_value = value_ff;
   assign rsp_output_position = opos_ff;
   assign rsp_last_of_line    = olast_ff;

`include "spectral_line_k_linear_resampler_macros.svh"

   `SLKR_ASSERT_IMP(a_start_only_idle, cmd.start, state_ff == ST_IDLE, "start while busy")
   `SLKR_ASSERT_IMP(a_pos_after_start, state_ff == ST_POS, $past(cmd.start), "pos without start")
   `SLKR_ASSERT_IMP(a_right_next_to_left, state_ff == ST_RDB,
      right_ff == left_ff || right_ff == left_ff + 1'b1, "right index not next to left")
   `SLKR_ASSERT_NXT(a_out_loads_word, state_ff == ST_OUT && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "result word not loaded")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench of the spectral line k-linear resampler
module tb_top;
   import slkr_pkg::*;

   localparam int LINE_MAX     = MAX_LINE_LENGTH_DEF;
   localparam int FRAC         = FRACTION_BITS_DEF;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 10;
   localparam int RANDOM_WORDS = 110;
   localparam int TABLE_SPAN   = 400;
   localparam longint SAT_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAT_LO   = -(longint'(1) << (SAMPLE_W - 1));

   localparam logic signed [TPOS_W-1:0] POS_MIN  = {1'b1, {(TPOS_W-1){1'b0}}};
   localparam logic signed [TPOS_W-1:0] POS_MAX  = {1'b0, {(TPOS_W-1){1'b1}}};
   localparam logic signed [TPOS_W-1:0] POS_HALF = TPOS_W'(1) << (FRAC - 1);
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct {
      slkr_action_type            action;
      logic [TADDR_W-1:0]         addr;
      logic signed [TPOS_W-1:0]   position;
      logic signed [SAMPLE_W-1:0] sample;
   } spectral_word_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic [OUT_POS_W-1:0]       position;
      logic                       last;
      logic                       check_value;
   } resampled_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ACTION_W-1:0]        req_action = '0;
   logic [TADDR_W-1:0]         req_table_address = '0;
   logic signed [TPOS_W-1:0]   req_resample_position = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_resampled_value;
   logic [OUT_POS_W-1:0]       rsp_output_position;
   logic                       rsp_last_of_line;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_W-1:0]           csr_line_length = '0;

   spectral_line_k_linear_resampler dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_table_address     (req_table_address),
      .req_resample_position (req_resample_position),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_resampled_value   (rsp_resampled_value),
      .rsp_output_position   (rsp_output_position),
      .rsp_last_of_line      (rsp_last_of_line),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_line_length       (csr_line_length)
   );

   always #5 clock = ~clock;

   // shadow of the block state
   logic signed [SAMPLE_W-1:0] line_banks [2][LINE_MAX];
   logic signed [TPOS_W-1:0]   position_map [LINE_MAX];
   bit                         line_written [2][LINE_MAX];
   bit                         table_loaded [LINE_MAX];
   int unsigned                line_count   = 0;
   logic                       fill_bank    = 1'b0;
   logic                       line_ready   = 1'b0;
   logic [CSR_W-1:0]           line_len_reg = LINE_LENGTH_RESET;

   spectral_word_type  outgoing_words [$];
   resampled_word_type awaited_words [$];
   int unsigned words_queued    = 0;
   int unsigned words_taken     = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes      = 0;
   int unsigned mismatches      = 0;
   int unsigned idle_cycles     = 0;
   int unsigned send_gap        = 0;
   int unsigned stall_left      = 0;
   logic        req_taken       = 1'b0;
   logic        quiet           = 1'b0;

   function automatic int unsigned eff_len();
      int unsigned n = line_len_reg;
      if (n < 2) n = 2;
      if (n > LINE_MAX) n = LINE_MAX;
      return n;
   endfunction

   function automatic void predict_resample(spectral_word_type w);
      int unsigned        len, pos;
      longint             p, left, right, top, f, a, b, v;
      logic               done;
      resampled_word_type r;
      len = eff_len();
      pos = line_count;
      if (w.action == ACT_LOAD) begin
         position_map[w.addr] = w.position;
         table_loaded[w.addr] = 1'b1;
         return;
      end
      if (w.action == ACT_NONE || (w.action == ACT_DRAIN && !line_ready))
         return;
      if (pos >= LINE_MAX) pos = LINE_MAX - 1;
      done = (pos + 1 >= len);
      if (line_ready) begin
         top = len;
         top = top - 1;
         p = position_map[pos];
         left = p >>> FRAC;
         if (left > top) left = top;
         if (left < 0) left = 0;
         right = (left + 1 > top) ? top : left + 1;
         // fraction is left unclamped so positions off the line extrapolate
         f = p - (left << FRAC);
         a = line_banks[~fill_bank][left];
         b = line_banks[~fill_bank][right];
         v = a + (((b - a) * f + (longint'(1) << (FRAC - 1))) >>> FRAC);
         if (v > SAT_HI) v = SAT_HI;
         else if (v < SAT_LO) v = SAT_LO;
         r.value    = SAMPLE_W'(v);
         r.position = OUT_POS_W'(pos);
         r.last     = done;
         // a never written line entry holds no defined sample
         r.check_value = table_loaded[pos] && line_written[~fill_bank][left]
                         && line_written[~fill_bank][right];
         awaited_words = {awaited_words, r};
      end
      if (w.action == ACT_SAMPLE) begin
         line_banks[fill_bank][pos]   = w.sample;
         line_written[fill_bank][pos] = 1'b1;
      end
      if (done) begin
         line_count = 0;
         fill_bank  = ~fill_bank;
         line_ready = (w.action == ACT_SAMPLE);
      end else begin
         line_count = pos + 1;
      end
   endfunction

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [TPOS_W-1:0] pick_position(int unsigned idx,
                                                              int unsigned len);
      int unsigned r    = $urandom_range(0, 99);
      longint      base = longint'(idx) << FRAC;
      longint      off  = longint'($urandom_range(0, 4 << FRAC)) - (longint'(2) << FRAC);
      if (r < 65) return TPOS_W'(base + off);
      if (r < 78) return TPOS_W'(longint'($urandom_range(0, (len << FRAC) - 1)));
      if (r < 90) return TPOS_W'($urandom);
      if (r < 95) return POS_MIN;
      return POS_MAX;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned r = $urandom_range(0, 99);
      if (r < 5) return SMP_MIN;
      if (r < 10) return SMP_MAX;
      return SAMPLE_W'($urandom);
   endfunction

   function automatic void queue_word(slkr_action_type act, logic [TADDR_W-1:0] addr,
                                      logic signed [TPOS_W-1:0] p,
                                      logic signed [SAMPLE_W-1:0] s);
      spectral_word_type w;
      w.action   = act;
      w.addr     = addr;
      w.position = p;
      w.sample   = s;
      outgoing_words = {outgoing_words, w};
      words_queued++;
   endfunction

   function automatic void queue_random_word();
      int unsigned r   = $urandom_range(0, 99);
      int unsigned len = eff_len();
      int unsigned addr;
      if (r < 76) begin
         queue_word(ACT_SAMPLE, TADDR_W'($urandom), TPOS_W'($urandom), pick_sample());
      end else if (r < 84) begin
         queue_word(ACT_DRAIN, TADDR_W'($urandom), TPOS_W'($urandom), pick_sample());
      end else if (r < 97) begin
         addr = $urandom_range(0, 1) ? $urandom_range(0, len - 1)
                                     : $urandom_range(0, LINE_MAX - 1);
         queue_word(ACT_LOAD, TADDR_W'(addr), pick_position(addr, len), pick_sample());
      end else begin
         queue_word(ACT_NONE, TADDR_W'($urandom), TPOS_W'($urandom), pick_sample());
      end
   endfunction

   // input word driver
   always @(negedge clock) begin
      spectral_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // word not taken yet, payload holds
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (outgoing_words.size() > 0) begin
         w = outgoing_words.pop_front();
         req_action            <= w.action;
         req_table_address     <= w.addr;
         req_resample_position <= w.position;
         req_sample            <= w.sample;
         req_valid             <= 1'b1;
         send_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      spectral_word_type  seen;
      resampled_word_type want;
      logic               fired;
      if (!reset) begin
         fired = 1'b0;
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.action   = slkr_action_type'(req_action);
            seen.addr     = req_table_address;
            seen.position = req_resample_position;
            seen.sample   = req_sample;
            predict_resample(seen);
            words_taken++;
            fired = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            line_len_reg = csr_line_length;
            csr_writes++;
            fired = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            fired = 1'b1;
            if (awaited_words.size() == 0) begin
               flag_mismatch($sformatf("unexpected word value %0d pos %0d last %0b",
                  rsp_resampled_value, rsp_output_position, rsp_last_of_line));
            end else begin
               want = awaited_words.pop_front();
               if ((want.check_value && rsp_resampled_value !== want.value) ||
                   rsp_output_position !== want.position ||
                   rsp_last_of_line !== want.last)
                  flag_mismatch($sformatf(
                     "expected value %0d pos %0d last %0b, got value %0d pos %0d last %0b",
                     want.value, want.position, want.last,
                     rsp_resampled_value, rsp_output_position, rsp_last_of_line));
            end
         end
         idle_cycles = fired ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_line_length(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_line_length <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender holds off until the block has nothing left in flight
   task automatic wait_idle();
      do @(negedge clock);
      while (words_taken != words_queued || awaited_words.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      int unsigned lens [12];
      lens = '{1, 2, 5, 17, 2047, 3, 4095, 0, 0, 0, 12, 9};
      lens[7] = $urandom_range(2, 40);
      lens[8] = $urandom_range(2, 40);
      lens[9] = $urandom_range(41, 300);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short lines: extremes, every action, first line, drains
      write_line_length('0);
      @(posedge clock);
      queue_word(ACT_DRAIN, '0, '0, '0);
      queue_word(ACT_NONE, '1, '1, '1);
      queue_word(ACT_LOAD, '0, POS_MIN, '0);
      queue_word(ACT_LOAD, TADDR_W'(1), POS_MAX, '0);
      queue_word(ACT_SAMPLE, '0, '0, SMP_MAX);
      queue_word(ACT_SAMPLE, '0, '0, SMP_MIN);
      queue_word(ACT_SAMPLE, '0, '0, SMP_MIN);
      queue_word(ACT_SAMPLE, '0, '0, SMP_MAX);
      queue_word(ACT_LOAD, '0, POS_HALF, '0);
      queue_word(ACT_LOAD, TADDR_W'(1), -POS_HALF, '0);
      queue_word(ACT_SAMPLE, '0, '0, SAMPLE_W'(5));
      queue_word(ACT_SAMPLE, '0, '0, SAMPLE_W'(-7));
      queue_word(ACT_DRAIN, '0, '0, '0);
      queue_word(ACT_DRAIN, '0, '0, '0);
      queue_word(ACT_DRAIN, '0, '0, '0);
      queue_word(ACT_LOAD, '0, '1, '0);
      queue_word(ACT_SAMPLE, '0, '0, SAMPLE_W'(100));
      queue_word(ACT_SAMPLE, '0, '0, SAMPLE_W'(-100));
      queue_word(ACT_SAMPLE, '0, '0, SAMPLE_W'(3));
      queue_word(ACT_DRAIN, '0, '0, '0);
      wait_idle();

      // position table for line positions 0 to 399
      @(posedge clock);
      for (int i = 0; i < TABLE_SPAN; i++)
         queue_word(ACT_LOAD, TADDR_W'(i), pick_position(i, LINE_MAX), pick_sample());
      wait_idle();

      // random traffic under a range of line lengths, switched mid-line
      for (int ph = 0; ph < 12; ph++) begin
         write_line_length(CSR_W'(lens[ph]));
         quiet = (ph % 4 == 2);
         @(posedge clock);
         for (int i = 0; i < RANDOM_WORDS; i++) begin
            queue_random_word();
            if (eff_len() <= 64 && $urandom_range(0, 99) < 2)
               repeat (eff_len() + 2) queue_word(ACT_DRAIN, '0, '0, '0);
         end
         wait_idle();
      end
      quiet = 1'b0;

      if (awaited_words.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", awaited_words.size()));
      $display("covered %0d input words, %0d resampled words checked, %0d line length writes",
               words_taken, results_checked, csr_writes);
      $display("line lengths from clamped minimum to clamped maximum, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* spectral_line_k_linear_resampler.f */
+incdir+rtl
rtl/slkr_pkg.sv
rtl/slkr_ram.sv
rtl/slkr_interp.sv
rtl/spectral_line_k_linear_resampler.sv
dv/tb_top.sv
